>>> design/lcf_pkg.sv
// Shared types, constants and the CRC-32 byte update for the length/CRC-32 framer.
// Depends on nothing; the core, the sequencer and the output register import it.
package lcf_pkg;

	localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
	localparam logic [31:0] CRC_INIT = 32'h0000_0000;

	// One input word: a payload byte with its frame marks and header length.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] frame_length;
	} item_t;

	// One output word of the framed stream.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       frame_end;
	} result_t;

	// Which byte of the current item goes out next.
	typedef enum logic [2:0] {
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA,
		PH_CRC3,
		PH_CRC2,
		PH_CRC1,
		PH_CRC0
	} phase_t;

	// MSB-first CRC-32 update by one byte, no reflection.
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h00_0000};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

>>> design/lcf_item_if.sv
// Input channel of the framer: valid/ready handshake carrying one payload word.
// Depends on nothing.
interface lcf_item_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [15:0] frame_length;

	modport source (output valid, output data_byte, output first_byte,
		output last_byte, output frame_length, input ready);
	modport sink (input valid, input data_byte, input first_byte,
		input last_byte, input frame_length, output ready);
endinterface

>>> design/lcf_result_if.sv
// Output channel of the framer: valid/ready handshake carrying one framed byte.
// Depends on nothing.
interface lcf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       frame_end;

	modport source (output valid, output out_byte, output run_end,
		output frame_end, input ready);
	modport sink (input valid, input out_byte, input run_end,
		input frame_end, output ready);
endinterface

>>> design/length_crc32_framer_core.sv
// Top level of the length-prefixed CRC-32 framer.
// Depends on lcf_pkg, lcf_item_if, lcf_result_if, lcf_sequencer and lcf_out_reg.
//
// Usage:
//   payload: input words, one payload byte each, with first_byte/last_byte marks;
//            frame_length is read on the first byte of a frame.
//   framed:  output words, one frame byte each: two length bytes (high first) on a
//            first byte, the payload byte, and four CRC-32 bytes (high first) after
//            a last byte. run_end marks the final byte produced by each input word,
//            frame_end the final CRC byte.
//   The CRC (poly 04C11DB7, MSB first, init 0, no final xor) covers length and
//   payload bytes; a first byte restarts it, the end of a trailer clears it.
// Timing:
//   One output byte per cycle while the receiver is ready. An input word yields 1 to
//   7 bytes; plain payload words go through at one per cycle while the receiver is
//   ready. An accepted input word reaches the output through the sequencer holding
//   register, then the output register.
// Reset clears the CRC and empties both stages. When the receiver stalls, the
// output register holds its word, the sequencer holds its phase and CRC, and
// payload.ready drops once the sequencer has a word it cannot finish.
module length_crc32_framer_core (
	input  logic      clk,
	input  logic      arst_n,
	lcf_item_if.sink  payload,
	lcf_result_if.source framed
);
	import lcf_pkg::*;

	item_t   item;
	result_t seq_word;
	result_t out_word;
	logic    seq_valid;
	logic    seq_ready;

	assign item.data_byte    = payload.data_byte;
	assign item.first_byte   = payload.first_byte;
	assign item.last_byte    = payload.last_byte;
	assign item.frame_length = payload.frame_length;

	lcf_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (payload.valid),
		.in_ready   (payload.ready),
		.in_item    (item),
		.emit_valid (seq_valid),
		.emit_ready (seq_ready),
		.emit       (seq_word)
	);

	lcf_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (seq_valid),
		.up_ready (seq_ready),
		.up_word  (seq_word),
		.dn_valid (framed.valid),
		.dn_ready (framed.ready),
		.dn_word  (out_word)
	);

	assign framed.out_byte  = out_word.out_byte;
	assign framed.run_end   = out_word.run_end;
	assign framed.frame_end = out_word.frame_end;

endmodule

>>> design/lcf_sequencer.sv
// Holds the current input word, steps through its header, payload and CRC bytes,
// and keeps the running CRC-32. Depends on lcf_pkg.
module lcf_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lcf_pkg::item_t   in_item,
	output logic             emit_valid,
	input  logic             emit_ready,
	output lcf_pkg::result_t emit
);
	import lcf_pkg::*;

	item_t       item_q;
	logic        busy_q;
	phase_t      phase_q;
	logic [31:0] crc_q;

	phase_t      phase_d;
	logic        busy_d;
	logic [31:0] crc_upd;
	logic        emit_fire;
	logic        in_fire;

	// Output decode: byte for the current phase and the CRC it leaves behind.
	always_comb begin
		emit.out_byte  = item_q.data_byte;
		emit.run_end   = 1'b0;
		emit.frame_end = 1'b0;
		crc_upd        = crc_q;
		unique case (phase_q)
			PH_LEN_HI: begin
				emit.out_byte = item_q.frame_length[15:8];
				crc_upd       = crc_feed(CRC_INIT, item_q.frame_length[15:8]);
			end
			PH_LEN_LO: begin
				emit.out_byte = item_q.frame_length[7:0];
				crc_upd       = crc_feed(crc_q, item_q.frame_length[7:0]);
			end
			PH_DATA: begin
				emit.out_byte = item_q.data_byte;
				emit.run_end  = ~item_q.last_byte;
				crc_upd       = crc_feed(crc_q, item_q.data_byte);
			end
			PH_CRC3: emit.out_byte = crc_q[31:24];
			PH_CRC2: emit.out_byte = crc_q[23:16];
			PH_CRC1: emit.out_byte = crc_q[15:8];
			PH_CRC0: begin
				emit.out_byte  = crc_q[7:0];
				emit.run_end   = 1'b1;
				emit.frame_end = 1'b1;
				crc_upd        = CRC_INIT;
			end
		endcase
	end

	assign emit_valid = busy_q;
	assign emit_fire  = busy_q & emit_ready;
	// Take the next word while the last byte of this one leaves.
	assign in_ready   = ~busy_q | (emit_ready & emit.run_end);
	assign in_fire    = in_valid & in_ready;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		busy_d  = busy_q;
		if (emit_fire) begin
			if (emit.run_end) begin
				busy_d = 1'b0;
			end else begin
				unique case (phase_q)
					PH_LEN_HI: phase_d = PH_LEN_LO;
					PH_LEN_LO: phase_d = PH_DATA;
					PH_DATA:   phase_d = PH_CRC3;
					PH_CRC3:   phase_d = PH_CRC2;
					PH_CRC2:   phase_d = PH_CRC1;
					PH_CRC1:   phase_d = PH_CRC0;
					PH_CRC0:   phase_d = PH_CRC0;
				endcase
			end
		end
		if (in_fire) begin
			busy_d  = 1'b1;
			phase_d = in_item.first_byte ? PH_LEN_HI : PH_DATA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_DATA;
			crc_q   <= CRC_INIT;
		end else begin
			busy_q  <= busy_d;
			phase_q <= phase_d;
			if (emit_fire) begin
				crc_q <= crc_upd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_item;
		end
	end

	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && phase_q == PH_CRC0) |=> (crc_q == CRC_INIT))
		else $error("crc not cleared after trailer");

	a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_valid && emit.frame_end) |-> emit.run_end)
		else $error("frame_end without run_end");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !emit_ready) |=> ($stable(phase_q) && $stable(crc_q) && busy_q))
		else $error("sequencer moved while stalled");

	a_header_order: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && phase_q == PH_LEN_HI) |=> (busy_q && phase_q == PH_LEN_LO))
		else $error("length low byte did not follow high byte");

endmodule

>>> design/lcf_out_reg.sv
// Output register between the sequencer and the result channel.
// Depends on lcf_pkg.
module lcf_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  lcf_pkg::result_t up_word,
	output logic             dn_valid,
	input  logic             dn_ready,
	output lcf_pkg::result_t dn_word
);
	import lcf_pkg::*;

	logic    valid_q;
	result_t word_q;

	// Load when empty or when the held word leaves this cycle.
	assign up_ready = ~valid_q | dn_ready;
	assign dn_valid = valid_q;
	assign dn_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_q <= up_word;
		end
	end

endmodule
